[src/cnv_pkg.sv]
// ----------------------------------------------------------------------------
// cnv_pkg
// shared constants, types and register codes of the 3x3 rgb convolution
// ----------------------------------------------------------------------------
package cnv_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;

	localparam int COL_W       = $clog2(MAX_WIDTH);
	localparam int ROW_W       = $clog2(MAX_HEIGHT);
	localparam int WIDTH_REG_W = 11;
	localparam int KERNEL_W    = 24;
	localparam int DIV_W       = 8;
	localparam int CH_W        = 8;
	localparam int PIX_W       = 3 * CH_W;
	localparam int WEIGHT_W    = 8;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 24;

	// nine taps of 8-bit signed weight times 8-bit pixel fit in 20 signed bits
	localparam int PROD_W = WEIGHT_W + CH_W + 1;
	localparam int SUM_W  = 20;
	localparam int MAG_W  = SUM_W - 1;
	localparam int NUM_W  = MAG_W + 2;
	localparam int DEN_W  = DIV_W + 1;
	localparam int QUO_W  = CH_W;
	localparam int QBIT_W = $clog2(QUO_W);

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_KERNEL_TOP    = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_KERNEL_MIDDLE = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_KERNEL_BOTTOM = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_DIVISOR       = 3'd4;

	localparam logic [WIDTH_REG_W-1:0] IMAGE_WIDTH_RESET = 11'd92;
	localparam logic [KERNEL_W-1:0]    KERNEL_TOP_RESET  = 24'h010201;
	localparam logic [KERNEL_W-1:0]    KERNEL_MID_RESET  = 24'h020302;
	localparam logic [KERNEL_W-1:0]    KERNEL_BOT_RESET  = 24'h010201;
	localparam logic [DIV_W-1:0]       DIVISOR_RESET     = 8'd15;

	localparam logic [WIDTH_REG_W-1:0] MIN_IMAGE_WIDTH = 11'd3;

	typedef logic [PIX_W-1:0] pixel_t;

	// window row 0 is the line above, column 0 the leftmost pixel
	typedef struct packed {
		pixel_t [2:0][2:0]  win;
		logic [COL_W-1:0]   column;
		logic [ROW_W-1:0]   row;
	} cnv_job_t;

	typedef struct packed {
		logic              empty;
		logic [QCNT_W-1:0] count;
	} cnv_qstat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAC,
		ST_PREP,
		ST_DIV,
		ST_HOLD
	} cnv_state_t;

endpackage

[src/cnv_ram.sv]
// ----------------------------------------------------------------------------
// cnv_ram
// simple dual-port ram, one write port and one registered read port
// ----------------------------------------------------------------------------
module cnv_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[src/cnv_front.sv]
// ----------------------------------------------------------------------------
// cnv_front
// takes pixels, tracks raster position, keeps two line stores and the
// 3x3 window, and hands interior windows to the queue
// ----------------------------------------------------------------------------
module cnv_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	output logic                             full,
	input  logic [7:0]                       in_red,
	input  logic [7:0]                       in_green,
	input  logic [7:0]                       in_blue,
	input  logic                             frame_start,
	input  logic [cnv_pkg::WIDTH_REG_W-1:0]  image_width,
	input  cnv_pkg::cnv_qstat_t              qstat,
	output logic                             job_push,
	output cnv_pkg::cnv_job_t                job
);
	import cnv_pkg::*;

	logic                   accept;
	logic [COL_W-1:0]       col_q;
	logic [ROW_W-1:0]       row_q;
	logic [COL_W-1:0]       x;
	logic [ROW_W-1:0]       y;
	logic [COL_W:0]         x_inc;
	logic [WIDTH_REG_W-1:0] w_eff;
	logic                   line_end;
	logic [QCNT_W:0]        occupancy;

	logic                   valid_s1;
	pixel_t                 px_s1;
	logic [COL_W-1:0]       x_s1;
	logic [ROW_W-1:0]       y_s1;
	logic                   fwd_s1;
	logic [2*PIX_W-1:0]     fwd_data_s1;

	logic [2*PIX_W-1:0]     rdata;
	logic [2*PIX_W-1:0]     lines;
	pixel_t                 top_px;
	pixel_t                 mid_px;
	pixel_t [2:0][2:0]      win_q;
	pixel_t [2:0][2:0]      win_d;

	// room for the item in flight plus the new one
	assign occupancy = (QCNT_W+1)'(qstat.count) + (QCNT_W+1)'(valid_s1);
	assign full      = occupancy >= (QCNT_W+1)'(QUEUE_DEPTH);
	assign accept    = push && !full;

	assign x     = frame_start ? '0 : col_q;
	assign y     = frame_start ? '0 : row_q;
	assign x_inc = (COL_W+1)'(x) + (COL_W+1)'(1);

	always_comb begin
		priority if (image_width < MIN_IMAGE_WIDTH) begin
			w_eff = MIN_IMAGE_WIDTH;
		end else if (image_width > WIDTH_REG_W'(MAX_WIDTH)) begin
			w_eff = WIDTH_REG_W'(MAX_WIDTH);
		end else begin
			w_eff = image_width;
		end
	end

	assign line_end = WIDTH_REG_W'(x_inc) >= w_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (line_end) begin
				col_q <= '0;
				row_q <= (y == ROW_W'(MAX_HEIGHT - 1)) ? '0 : y + ROW_W'(1);
			end else begin
				col_q <= x_inc[COL_W-1:0];
				row_q <= y;
			end
		end
	end

	// both lines share one address: {two lines above, one line above} the pixel read
	cnv_ram #(
		.WIDTH (2 * PIX_W),
		.DEPTH (MAX_WIDTH)
	) u_lines (
		.clk   (clk),
		.we    (valid_s1),
		.waddr (x_s1),
		.wdata ({mid_px, px_s1}),
		.re    (accept),
		.raddr (x),
		.rdata (rdata)
	);

	// a read in the same cycle as a write to that column gets the new data
	assign lines  = fwd_s1 ? fwd_data_s1 : rdata;
	assign top_px = lines[2*PIX_W-1:PIX_W];
	assign mid_px = lines[PIX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_s1   <= 1'b0;
		end else begin
			valid_s1 <= accept;
			fwd_s1   <= accept && valid_s1 && (x == x_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1       <= {in_red, in_green, in_blue};
			x_s1        <= x;
			y_s1        <= y;
			fwd_data_s1 <= {mid_px, px_s1};
		end
	end

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			win_d[r][0] = win_q[r][1];
			win_d[r][1] = win_q[r][2];
		end
		win_d[0][2] = top_px;
		win_d[1][2] = mid_px;
		win_d[2][2] = px_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (valid_s1) begin
			win_q <= win_d;
		end
	end

	assign job_push   = valid_s1 && (x_s1 >= COL_W'(2)) && (y_s1 >= ROW_W'(2));
	assign job.win    = win_d;
	assign job.column = x_s1 - COL_W'(2);
	assign job.row    = y_s1 - ROW_W'(2);

	a_frame_origin: assert property (@(posedge clk) disable iff (!arst_n)
		accept && frame_start |=> valid_s1 && x_s1 == '0 && y_s1 == '0)
		else $error("frame start did not restart the position");

endmodule

[src/cnv_queue.sv]
// ----------------------------------------------------------------------------
// cnv_queue
// short fifo of windows between the front and the arithmetic back end
// ----------------------------------------------------------------------------
module cnv_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  cnv_pkg::cnv_job_t    wr_job,
	input  logic                 rd_en,
	output cnv_pkg::cnv_job_t    rd_job,
	output cnv_pkg::cnv_qstat_t  qstat
);
	import cnv_pkg::*;

	cnv_job_t          slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wptr_q;
	logic [QPTR_W-1:0] rptr_q;
	logic [QCNT_W-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (wr_en) begin
				wptr_q <= wptr_q + QPTR_W'(1);
			end
			if (rd_en) begin
				rptr_q <= rptr_q + QPTR_W'(1);
			end
			unique case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wptr_q] <= wr_job;
		end
	end

	assign rd_job      = slot_q[rptr_q];
	assign qstat.empty = (count_q == '0);
	assign qstat.count = count_q;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> count_q != QCNT_W'(QUEUE_DEPTH) || rd_en)
		else $error("window queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> count_q != '0)
		else $error("window queue underflow");

endmodule

[src/cnv_back.sv]
// ----------------------------------------------------------------------------
// cnv_back
// per window: nine multiply-accumulate steps for all three channels, then
// a rounded division by the divisor, clamp, and the output register
// ----------------------------------------------------------------------------
module cnv_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cnv_pkg::cnv_qstat_t           qstat,
	input  cnv_pkg::cnv_job_t             job,
	output logic                          job_pop,
	input  logic [cnv_pkg::KERNEL_W-1:0]  kernel_top_row,
	input  logic [cnv_pkg::KERNEL_W-1:0]  kernel_middle_row,
	input  logic [cnv_pkg::KERNEL_W-1:0]  kernel_bottom_row,
	input  logic [cnv_pkg::DIV_W-1:0]     divisor,
	output logic                          empty,
	input  logic                          pop,
	output logic [7:0]                    out_red,
	output logic [7:0]                    out_green,
	output logic [7:0]                    out_blue,
	output logic [9:0]                    out_column,
	output logic [9:0]                    out_row
);
	import cnv_pkg::*;

	cnv_state_t              state_q;
	cnv_state_t              state_d;
	logic                    load_out;
	logic                    last_tap;

	cnv_job_t                job_q;
	logic [1:0]              tap_row_q;
	logic [1:0]              tap_col_q;
	logic signed [SUM_W-1:0] acc_q [3];
	logic [NUM_W-1:0]        rem_q [3];
	logic [QUO_W-1:0]        quo_q [3];
	logic [QBIT_W-1:0]       bit_q;
	logic [DEN_W-1:0]        den_q;
	logic                    out_valid_q;

	logic [KERNEL_W-1:0]     kernel_word;
	logic signed [WEIGHT_W-1:0] weight;
	pixel_t                  tap_px;
	logic [DIV_W-1:0]        d_eff;
	logic [DEN_W-1:0]        den;
	logic [NUM_W-1:0]        step_sub;

	assign last_tap = (tap_row_q == 2'd2) && (tap_col_q == 2'd2);
	assign d_eff    = (divisor == '0) ? DIV_W'(1) : divisor;
	assign den      = {d_eff, 1'b0};
	assign step_sub = NUM_W'(den_q) << bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		job_pop  = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (!qstat.empty) begin
					job_pop = 1'b1;
					state_d = ST_MAC;
				end
			end
			ST_MAC: begin
				if (last_tap) begin
					state_d = ST_PREP;
				end
			end
			ST_PREP: begin
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (bit_q == '0) begin
					state_d = ST_HOLD;
				end
			end
			ST_HOLD: begin
				if (!out_valid_q || pop) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		unique case (tap_row_q)
			2'd0:    kernel_word = kernel_top_row;
			2'd1:    kernel_word = kernel_middle_row;
			default: kernel_word = kernel_bottom_row;
		endcase
		unique case (tap_col_q)
			2'd0:    weight = kernel_word[23:16];
			2'd1:    weight = kernel_word[15:8];
			default: weight = kernel_word[7:0];
		endcase
		tap_px = job_q.win[tap_row_q][tap_col_q];
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				job_q     <= job;
				tap_row_q <= '0;
				tap_col_q <= '0;
				for (int ch = 0; ch < 3; ch++) begin
					acc_q[ch] <= '0;
				end
			end
			ST_MAC: begin
				for (int ch = 0; ch < 3; ch++) begin
					logic signed [PROD_W-1:0] prod;
					prod = weight * $signed({1'b0, tap_px[(2 - ch) * CH_W +: CH_W]});
					acc_q[ch] <= acc_q[ch] + SUM_W'(prod);
				end
				if (tap_col_q == 2'd2) begin
					tap_col_q <= '0;
					tap_row_q <= tap_row_q + 2'd1;
				end else begin
					tap_col_q <= tap_col_q + 2'd1;
				end
			end
			ST_PREP: begin
				// (2*sum + d) / (2*d) rounds half away from zero for sum > 0
				for (int ch = 0; ch < 3; ch++) begin
					logic [NUM_W-1:0] num;
					num = NUM_W'({acc_q[ch][MAG_W-1:0], 1'b0}) + NUM_W'(d_eff);
					priority if (acc_q[ch][SUM_W-1] || acc_q[ch] == '0) begin
						quo_q[ch] <= '0;
						rem_q[ch] <= '0;
					end else if (num >= NUM_W'({den, {QUO_W{1'b0}}})) begin
						quo_q[ch] <= '1;
						rem_q[ch] <= '0;
					end else begin
						quo_q[ch] <= '0;
						rem_q[ch] <= num;
					end
				end
				bit_q <= QBIT_W'(QUO_W - 1);
				den_q <= den;
			end
			ST_DIV: begin
				for (int ch = 0; ch < 3; ch++) begin
					if (rem_q[ch] >= step_sub) begin
						rem_q[ch]        <= rem_q[ch] - step_sub;
						quo_q[ch][bit_q] <= 1'b1;
					end
				end
				bit_q <= bit_q - QBIT_W'(1);
			end
			ST_HOLD: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_red    <= quo_q[0];
			out_green  <= quo_q[1];
			out_blue   <= quo_q[2];
			out_column <= job_q.column;
			out_row    <= job_q.row;
		end
	end

	assign empty = !out_valid_q;

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |-> !qstat.empty && state_q == ST_IDLE)
		else $error("back end took a window from an empty queue");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |->
			rem_q[0] < (NUM_W'(den_q) << (4'(bit_q) + 4'd1)) &&
			rem_q[1] < (NUM_W'(den_q) << (4'(bit_q) + 4'd1)) &&
			rem_q[2] < (NUM_W'(den_q) << (4'(bit_q) + 4'd1)))
		else $error("divider remainder out of range");

	a_hold_waits: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_HOLD && out_valid_q && !pop |=> state_q == ST_HOLD && out_valid_q)
		else $error("result overwritten before it was taken");

endmodule

[src/rgb_convolution_3x3.sv]
// ----------------------------------------------------------------------------
// rgb_convolution_3x3
// 3x3 rgb convolution over a raster pixel stream with configurable kernel
// ----------------------------------------------------------------------------
// Pixels are pushed in raster order, one per clock while full is low;
// frame_start marks the first pixel of an image. Border pixels (first two
// columns or rows) give no result. Each interior pixel gives one result from
// the shared arithmetic unit (9 multiply-accumulate steps over the taps, 1
// rounding setup, 8 quotient bits, plus hand-off), which takes a new window
// only after handing off the last; a four-entry window queue absorbs bursts
// and full rises when it is taken up. Results come out in input order with
// their position in the border-stripped image. The user writes configuration
// registers through cfg_write/cfg_index/cfg_data (0 width, 1..3 kernel rows,
// 4 divisor) only while no pixel is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module rgb_convolution_3x3 (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  logic [7:0]                      in_red,
	input  logic [7:0]                      in_green,
	input  logic [7:0]                      in_blue,
	input  logic                            frame_start,
	output logic                            empty,
	input  logic                            pop,
	output logic [7:0]                      out_red,
	output logic [7:0]                      out_green,
	output logic [7:0]                      out_blue,
	output logic [9:0]                      out_column,
	output logic [9:0]                      out_row,
	input  logic                            cfg_write,
	input  logic [cnv_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [cnv_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import cnv_pkg::*;

	logic [WIDTH_REG_W-1:0] image_width_q;
	logic [KERNEL_W-1:0]    kernel_top_q;
	logic [KERNEL_W-1:0]    kernel_mid_q;
	logic [KERNEL_W-1:0]    kernel_bot_q;
	logic [DIV_W-1:0]       divisor_q;

	cnv_qstat_t qstat;
	cnv_job_t   push_job;
	cnv_job_t   head_job;
	logic       job_push;
	logic       job_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q <= IMAGE_WIDTH_RESET;
			kernel_top_q  <= KERNEL_TOP_RESET;
			kernel_mid_q  <= KERNEL_MID_RESET;
			kernel_bot_q  <= KERNEL_BOT_RESET;
			divisor_q     <= DIVISOR_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:   image_width_q <= cfg_data[WIDTH_REG_W-1:0];
				REG_KERNEL_TOP:    kernel_top_q  <= cfg_data[KERNEL_W-1:0];
				REG_KERNEL_MIDDLE: kernel_mid_q  <= cfg_data[KERNEL_W-1:0];
				REG_KERNEL_BOTTOM: kernel_bot_q  <= cfg_data[KERNEL_W-1:0];
				REG_DIVISOR:       divisor_q     <= cfg_data[DIV_W-1:0];
				default: begin
				end
			endcase
		end
	end

	cnv_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.in_red      (in_red),
		.in_green    (in_green),
		.in_blue     (in_blue),
		.frame_start (frame_start),
		.image_width (image_width_q),
		.qstat       (qstat),
		.job_push    (job_push),
		.job         (push_job)
	);

	cnv_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (job_push),
		.wr_job (push_job),
		.rd_en  (job_pop),
		.rd_job (head_job),
		.qstat  (qstat)
	);

	cnv_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.qstat             (qstat),
		.job               (head_job),
		.job_pop           (job_pop),
		.kernel_top_row    (kernel_top_q),
		.kernel_middle_row (kernel_mid_q),
		.kernel_bottom_row (kernel_bot_q),
		.divisor           (divisor_q),
		.empty             (empty),
		.pop               (pop),
		.out_red           (out_red),
		.out_green         (out_green),
		.out_blue          (out_blue),
		.out_column        (out_column),
		.out_row           (out_row)
	);

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the 3x3 rgb convolution
// ----------------------------------------------------------------------------
// Pixels are pushed in raster frames while results are popped with random
// stalls on both sides. Every accepted pixel runs through a line-store and
// window model of the filter kept here; the queue of filtered pixels it
// yields is matched field by field against what the block hands out.
// Filter settings change only once the block has drained: a few hand-picked
// frames first, then random settings and frames, then one last frame with
// no stalls on either side.
// ----------------------------------------------------------------------------
module testbench;

	import cnv_pkg::*;

	localparam int unsigned RANDOM_ITEMS  = 1600;
	localparam int unsigned SETTLE_CYCLES = 100;
	localparam int unsigned QUIET_LIMIT   = 2000;

	typedef struct {
		logic [CH_W-1:0]  red;
		logic [CH_W-1:0]  green;
		logic [CH_W-1:0]  blue;
		logic [COL_W-1:0] column;
		logic [ROW_W-1:0] row;
	} filtered_px_t;

	class convolution_board;
		logic [WIDTH_REG_W-1:0] width_reg;
		logic [KERNEL_W-1:0]    kernel_rows[3];
		logic [DIV_W-1:0]       div_reg;
		pixel_t                 older_line[MAX_WIDTH];
		pixel_t                 newer_line[MAX_WIDTH];
		pixel_t                 taps[3][3];
		int unsigned            col_pos;
		int unsigned            row_pos;
		filtered_px_t           due_results[$];
		int unsigned            faults;

		function new();
			width_reg      = IMAGE_WIDTH_RESET;
			kernel_rows[0] = KERNEL_TOP_RESET;
			kernel_rows[1] = KERNEL_MID_RESET;
			kernel_rows[2] = KERNEL_BOT_RESET;
			div_reg        = DIVISOR_RESET;
			foreach (older_line[i]) begin
				older_line[i] = '0;
				newer_line[i] = '0;
			end
			foreach (taps[r, c]) taps[r][c] = '0;
			col_pos = 0;
			row_pos = 0;
			faults  = 0;
		endfunction

		function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_IMAGE_WIDTH:   width_reg = data[WIDTH_REG_W-1:0];
				REG_KERNEL_TOP:    kernel_rows[0] = data[KERNEL_W-1:0];
				REG_KERNEL_MIDDLE: kernel_rows[1] = data[KERNEL_W-1:0];
				REG_KERNEL_BOTTOM: kernel_rows[2] = data[KERNEL_W-1:0];
				REG_DIVISOR:       div_reg = data[DIV_W-1:0];
				default: ;
			endcase
		endfunction

		// line length the block really uses
		function int unsigned line_length();
			if (width_reg < MIN_IMAGE_WIDTH)
				return 32'(MIN_IMAGE_WIDTH);
			if (width_reg > MAX_WIDTH)
				return MAX_WIDTH;
			return 32'(width_reg);
		endfunction

		// divide with ties away from zero, anything not positive ends at zero
		function logic [CH_W-1:0] round_channel(int sum, int unsigned d);
			int unsigned q;
			if (sum <= 0)
				return '0;
			q = (2 * sum + d) / (2 * d);
			return (q > 255) ? 8'd255 : q[CH_W-1:0];
		endfunction

		function void take_pixel(logic [CH_W-1:0] r, logic [CH_W-1:0] g, logic [CH_W-1:0] b,
				logic fs);
			int unsigned      w;
			int unsigned      d;
			int unsigned      x;
			int unsigned      y;
			int               sum;
			pixel_t           above;
			pixel_t           here;
			logic signed [7:0] wt;
			logic [CH_W-1:0]  lvl;
			logic [CH_W-1:0]  outs[3];
			filtered_px_t     res;
			w = line_length();
			d = (div_reg == 0) ? 1 : 32'(div_reg);
			if (fs) begin
				col_pos = 0;
				row_pos = 0;
			end
			x = (col_pos >= MAX_WIDTH) ? MAX_WIDTH - 1 : col_pos;
			y = row_pos;
			above = older_line[x];
			here  = newer_line[x];
			for (int rr = 0; rr < 3; rr++) begin
				taps[rr][0] = taps[rr][1];
				taps[rr][1] = taps[rr][2];
			end
			taps[0][2] = above;
			taps[1][2] = here;
			taps[2][2] = {r, g, b};
			older_line[x] = here;
			newer_line[x] = {r, g, b};
			if (x >= 2 && y >= 2) begin
				for (int ch = 0; ch < 3; ch++) begin
					sum = 0;
					for (int rr = 0; rr < 3; rr++)
						for (int cc = 0; cc < 3; cc++) begin
							wt  = kernel_rows[rr][(2 - cc) * 8 +: 8];
							lvl = taps[rr][cc][(2 - ch) * CH_W +: CH_W];
							sum += int'(wt) * int'(lvl);
						end
					outs[ch] = round_channel(sum, d);
				end
				res.red    = outs[0];
				res.green  = outs[1];
				res.blue   = outs[2];
				res.column = COL_W'(x - 2);
				res.row    = ROW_W'(y - 2);
				due_results.insert(due_results.size(), res);
			end
			if (x + 1 >= w) begin
				col_pos = 0;
				row_pos = (y + 1 >= MAX_HEIGHT) ? 0 : y + 1;
			end else begin
				col_pos = x + 1;
				row_pos = y;
			end
		endfunction

		function void check_field(string name, logic [9:0] want, logic [9:0] seen);
			if (seen !== want) begin
				$error("%s expected %0d, got %0d", name, want, seen);
				faults++;
			end
		endfunction

		function void match_result(filtered_px_t seen);
			filtered_px_t want;
			if (due_results.size() == 0) begin
				$error("filtered pixel out with no pixel waiting for one");
				faults++;
				return;
			end
			want = due_results.pop_front();
			check_field("out_red", 10'(want.red), 10'(seen.red));
			check_field("out_green", 10'(want.green), 10'(seen.green));
			check_field("out_blue", 10'(want.blue), 10'(seen.blue));
			check_field("out_column", want.column, seen.column);
			check_field("out_row", want.row, seen.row);
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n      = 1'b0;
	logic                   push        = 1'b0;
	logic                   full;
	logic [CH_W-1:0]        in_red      = '0;
	logic [CH_W-1:0]        in_green    = '0;
	logic [CH_W-1:0]        in_blue     = '0;
	logic                   frame_start = 1'b0;
	logic                   empty;
	logic                   pop         = 1'b0;
	logic [CH_W-1:0]        out_red;
	logic [CH_W-1:0]        out_green;
	logic [CH_W-1:0]        out_blue;
	logic [9:0]             out_column;
	logic [9:0]             out_row;
	logic                   cfg_write   = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index   = REG_IMAGE_WIDTH;
	logic [CFG_DATA_W-1:0]  cfg_data    = '0;

	convolution_board board = new();
	int unsigned      sent        = 0;
	int unsigned      idle_odds   = 0;
	int unsigned      stall_odds  = 0;
	int unsigned      stall_left  = 0;
	bit               calm        = 1'b0;

	rgb_convolution_3x3 i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.in_red      (in_red),
		.in_green    (in_green),
		.in_blue     (in_blue),
		.frame_start (frame_start),
		.empty       (empty),
		.pop         (pop),
		.out_red     (out_red),
		.out_green   (out_green),
		.out_blue    (out_blue),
		.out_column  (out_column),
		.out_row     (out_row),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [CH_W-1:0] random_level();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return CH_W'($urandom);
		endcase
	endfunction

	function automatic logic [KERNEL_W-1:0] random_kernel_row(bit wild);
		logic [KERNEL_W-1:0] row;
		if (wild)
			return KERNEL_W'($urandom);
		// small weights from -2 to 6 keep the results away from the clamps
		for (int i = 0; i < 3; i++)
			row[i * 8 +: 8] = 8'($urandom_range(8) - 2);
		return row;
	endfunction

	// one request per pixel; push stays high across back-to-back pixels
	task automatic send_pixel(logic [CH_W-1:0] r, logic [CH_W-1:0] g, logic [CH_W-1:0] b,
			logic fs);
		push        <= 1'b1;
		in_red      <= r;
		in_green    <= g;
		in_blue     <= b;
		frame_start <= fs;
		do @(posedge clk); while (full);
		board.take_pixel(r, g, b, fs);
		sent++;
		if (!calm && idle_odds != 0 && $urandom_range(idle_odds - 1) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(13, 1)) @(posedge clk);
		end
	endtask

	// border pixels may still sit in the block after the last result
	task automatic wait_drained();
		push <= 1'b0;
		while (board.due_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		board.set_reg(idx, data);
	endtask

	task automatic program_filter(logic [WIDTH_REG_W-1:0] width, logic [KERNEL_W-1:0] top,
			logic [KERNEL_W-1:0] mid, logic [KERNEL_W-1:0] bot, logic [DIV_W-1:0] div);
		write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(width));
		write_reg(REG_KERNEL_TOP, top);
		write_reg(REG_KERNEL_MIDDLE, mid);
		write_reg(REG_KERNEL_BOTTOM, bot);
		write_reg(REG_DIVISOR, CFG_DATA_W'(div));
		cfg_write <= 1'b0;
	endtask

	task automatic program_random(logic [WIDTH_REG_W-1:0] width);
		bit wild;
		wild = ($urandom_range(2) == 0);
		program_filter(width, random_kernel_row(wild), random_kernel_row(wild),
			random_kernel_row(wild),
			($urandom_range(3) == 0) ? DIV_W'($urandom) : DIV_W'($urandom_range(24, 1)));
	endtask

	task automatic send_lines(int unsigned count, bit fresh, int unsigned stray_odds);
		for (int unsigned i = 0; i < count; i++)
			send_pixel(random_level(), random_level(), random_level(),
				(i == 0 && fresh) || (stray_odds != 0 && $urandom_range(stray_odds - 1) == 0));
	endtask

	// receiving side: check what was popped, then pick pop for the next cycle
	always @(posedge clk) begin
		filtered_px_t seen;
		if (pop && !empty) begin
			seen.red    = out_red;
			seen.green  = out_green;
			seen.blue   = out_blue;
			seen.column = out_column;
			seen.row    = out_row;
			board.match_result(seen);
		end
		if (stall_left > 0)
			stall_left--;
		else if (!calm && stall_odds != 0 && $urandom_range(stall_odds - 1) == 0)
			stall_left = $urandom_range(13, 1);
		pop <= arst_n && (stall_left == 0);
	end

	initial begin
		int unsigned quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (push && !full) || (pop && !empty))
				quiet = 0;
			else
				quiet++;
		end
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		int unsigned width_now;
		int unsigned raw_width;
		bit          carry_on;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// saturation high: largest weights, zero divisor, width below the minimum
		program_filter('0, 24'h7F7F7F, 24'h7F7F7F, 24'h7F7F7F, '0);
		for (int k = 0; k < 9; k++)
			send_pixel('1, '0, (k % 2) ? 8'hFF : 8'h00, k == 0);
		wait_drained();
		// negative sums clamp to zero
		program_filter(11'd3, 24'h808080, 24'h808080, 24'h808080, '1);
		for (int k = 0; k < 9; k++)
			send_pixel('1, 8'h80, 8'h7F, k == 0);
		wait_drained();
		// centre tap alone over two: every channel lands on a half
		program_filter(11'd3, '0, 24'h000100, '0, 8'd2);
		for (int k = 0; k < 9; k++)
			if (k == 4)
				send_pixel(8'd5, 8'd3, 8'd255, 1'b0);
			else
				send_pixel(random_level(), random_level(), random_level(), k == 0);

		width_now = 3;
		while (sent < RANDOM_ITEMS) begin
			wait_drained();
			idle_odds  = ($urandom_range(2) == 0) ? 0 : $urandom_range(12, 3);
			stall_odds = ($urandom_range(2) == 0) ? 0 : $urandom_range(12, 3);
			// sometimes keep the running frame and shrink or keep the line under it
			carry_on = ($urandom_range(3) == 0);
			if (carry_on)
				raw_width = $urandom_range(width_now, 3);
			else if ($urandom_range(7) == 0)
				raw_width = $urandom_range(2);
			else if ($urandom_range(5) == 0)
				raw_width = $urandom_range(40, 13);
			else
				raw_width = $urandom_range(12, 3);
			program_random(WIDTH_REG_W'(raw_width));
			width_now = board.line_length();
			send_lines(width_now * $urandom_range(6, 3), !carry_on, 60);
		end

		// last frame runs with no stalls on either side
		wait_drained();
		calm = 1'b1;
		program_random(11'd12);
		send_lines(12 * 8, 1'b1, 0);

		wait_drained();
		if (board.faults == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
